// ===== sv/tcsc_pkg.sv =====
// Shared types, constants and helper functions for the symmetry canonicaliser.
// Needs nothing else; the interfaces and the top level import it.
`default_nettype none

package tcsc_pkg;

    localparam int CODE_W     = 44;
    localparam int NUM_DIGITS = 10;
    localparam int DIGIT_W    = 5;
    localparam int NUM_STATES = 5;
    localparam int NUM_PERMS  = 24;
    localparam int MULT_W     = 5;
    localparam int KEY_W      = NUM_DIGITS * DIGIT_W;
    localparam int DIGIT_BASE = 20;
    localparam int MAX_DIGIT  = DIGIT_BASE - 1;
    localparam int STRIDE_W   = 2;
    localparam int STATE_W    = 3;

    typedef logic [CODE_W-1:0]  code_t;
    typedef logic [CODE_W:0]    diff_t;
    typedef logic [DIGIT_W-1:0] digit_t;
    typedef logic [KEY_W-1:0]   key_t;
    typedef logic [STATE_W-1:0] state_t;
    typedef logic [MULT_W-1:0]  mult_t;
    typedef logic [NUM_PERMS-1:0] perm_vec_t;

    // Start state stays at 0; states 1..4 take every ordering.
    localparam state_t PERM_MAP [NUM_PERMS][NUM_STATES] = '{
        '{3'd0, 3'd1, 3'd2, 3'd3, 3'd4}, '{3'd0, 3'd1, 3'd2, 3'd4, 3'd3},
        '{3'd0, 3'd1, 3'd3, 3'd2, 3'd4}, '{3'd0, 3'd1, 3'd3, 3'd4, 3'd2},
        '{3'd0, 3'd1, 3'd4, 3'd2, 3'd3}, '{3'd0, 3'd1, 3'd4, 3'd3, 3'd2},
        '{3'd0, 3'd2, 3'd1, 3'd3, 3'd4}, '{3'd0, 3'd2, 3'd1, 3'd4, 3'd3},
        '{3'd0, 3'd2, 3'd3, 3'd1, 3'd4}, '{3'd0, 3'd2, 3'd3, 3'd4, 3'd1},
        '{3'd0, 3'd2, 3'd4, 3'd1, 3'd3}, '{3'd0, 3'd2, 3'd4, 3'd3, 3'd1},
        '{3'd0, 3'd3, 3'd1, 3'd2, 3'd4}, '{3'd0, 3'd3, 3'd1, 3'd4, 3'd2},
        '{3'd0, 3'd3, 3'd2, 3'd1, 3'd4}, '{3'd0, 3'd3, 3'd2, 3'd4, 3'd1},
        '{3'd0, 3'd3, 3'd4, 3'd1, 3'd2}, '{3'd0, 3'd3, 3'd4, 3'd2, 3'd1},
        '{3'd0, 3'd4, 3'd1, 3'd2, 3'd3}, '{3'd0, 3'd4, 3'd1, 3'd3, 3'd2},
        '{3'd0, 3'd4, 3'd2, 3'd1, 3'd3}, '{3'd0, 3'd4, 3'd2, 3'd3, 3'd1},
        '{3'd0, 3'd4, 3'd3, 3'd1, 3'd2}, '{3'd0, 3'd4, 3'd3, 3'd2, 3'd1}
    };

    // mult * 20^(9-pos), worked out at elaboration
    function automatic diff_t digit_step(input int pos, input int mult);
        logic [63:0] w;
        w = 64'd1;
        for (int i = 0; i < NUM_DIGITS - 1 - pos; i++)
        begin
            w = w * 64'(DIGIT_BASE);
        end
        w = w * 64'(mult);
        return w[CODE_W:0];
    endfunction

    // next-state relabel; codes above the last state never occur in range
    function automatic state_t map_state(input int p, input state_t ns);
        state_t r;
        r = '0;
        case (ns)
            3'd0:    r = PERM_MAP[p][0];
            3'd1:    r = PERM_MAP[p][1];
            3'd2:    r = PERM_MAP[p][2];
            3'd3:    r = PERM_MAP[p][3];
            3'd4:    r = PERM_MAP[p][4];
            default: r = '0;
        endcase
        return r;
    endfunction

    // 24 / count, integer quotient
    function automatic mult_t orbit_size(input mult_t cnt);
        mult_t r;
        r = '0;
        case (cnt) inside
            5'd1:            r = 5'd24;
            5'd2:            r = 5'd12;
            5'd3:            r = 5'd8;
            5'd4:            r = 5'd6;
            5'd5, 5'd6:      r = 5'd4;
            5'd7, 5'd8:      r = 5'd3;
            [5'd9:5'd12]:    r = 5'd2;
            [5'd13:5'd24]:   r = 5'd1;
            default:         r = '0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== sv/tcsc_if.sv =====
// Request and result channel interfaces for the symmetry canonicaliser.
// Depends on tcsc_pkg for payload types.
`default_nettype none

interface tcsc_item_if;
    import tcsc_pkg::*;
    logic  valid;
    logic  ready;
    code_t machine_code;
    modport source (output valid, output machine_code, input ready);
    modport sink   (input valid, input machine_code, output ready);
endinterface

interface tcsc_result_if;
    import tcsc_pkg::*;
    logic  valid;
    logic  ready;
    mult_t multiplicity;
    logic  is_canonical;
    logic  out_of_range;
    modport source (output valid, output multiplicity, output is_canonical,
                    output out_of_range, input ready);
    modport sink   (input valid, input multiplicity, input is_canonical,
                    input out_of_range, output ready);
endinterface

`default_nettype wire

// ===== sv/turing_code_symmetry_canonicalizer_top.sv =====
// Top level of the symmetry canonicaliser: digit split pipeline, relabel compare,
// orbit size. Depends on tcsc_pkg and the interfaces in tcsc_if.sv.
//
//   channel   dir   payload                                    handshake
//   item      in    machine_code[43:0]                         valid/ready
//   result    out   multiplicity[4:0], is_canonical,           valid/ready
//                   out_of_range
//
// One request per cycle when not stalled: ten stages each peel one base-20
// digit by parallel trial subtraction, one stage compares all 24 relabelings,
// one stage counts fixers and registers the result.
// Each stage holds its own valid bit and loads when empty or when the next one
// moves, so stalls only back up as far as the bubbles allow. Reset clears the
// valid bits only.
`default_nettype none

module turing_code_symmetry_canonicalizer_top (
    input  logic                 clk,
    input  logic                 rst_n,
    tcsc_item_if.sink            item,
    tcsc_result_if.source        result
);
    import tcsc_pkg::*;

    // digit stages
    logic [NUM_DIGITS-1:0] dv_reg;
    logic [NUM_DIGITS-1:0] stage_rdy;
    code_t  rem_reg  [NUM_DIGITS];
    code_t  rem_next [NUM_DIGITS];
    digit_t dig_reg  [NUM_DIGITS][NUM_DIGITS];
    digit_t dig_next [NUM_DIGITS][NUM_DIGITS];
    logic [NUM_DIGITS-1:0] oor_reg;
    logic [NUM_DIGITS-1:0] oor_next;
    logic [NUM_DIGITS-1:0] src_valid;

    // compare stage
    logic      cv_reg;
    logic      cmp_rdy;
    perm_vec_t eq_reg, eq_next;
    perm_vec_t lt_reg, lt_next;
    logic      coor_reg;

    // output stage
    logic  ov_reg;
    logic  out_rdy;
    mult_t mult_reg, mult_next;
    logic  canon_reg, canon_next;
    logic  ooro_reg;

    assign out_rdy = ~ov_reg | result.ready;
    assign cmp_rdy = ~cv_reg | out_rdy;

    always_comb
    begin
        stage_rdy[NUM_DIGITS-1] = ~dv_reg[NUM_DIGITS-1] | cmp_rdy;
        for (int k = NUM_DIGITS - 2; k >= 0; k--)
        begin
            stage_rdy[k] = ~dv_reg[k] | stage_rdy[k+1];
        end
    end

    assign item.ready = stage_rdy[0];

    genvar gk;
    generate
        for (gk = 0; gk < NUM_DIGITS; gk++)
        begin : g_digit
            code_t  src_rem;
            digit_t src_dig [NUM_DIGITS];
            logic   src_oor;

            if (gk == 0)
            begin : g_first
                always_comb
                begin
                    src_rem = item.machine_code;
                    for (int i = 0; i < NUM_DIGITS; i++)
                    begin
                        src_dig[i] = '0;
                    end
                    src_oor = 1'b0;
                end
                assign src_valid[gk] = item.valid;
            end
            else
            begin : g_rest
                always_comb
                begin
                    src_rem = rem_reg[gk-1];
                    for (int i = 0; i < NUM_DIGITS; i++)
                    begin
                        src_dig[i] = dig_reg[gk-1][i];
                    end
                    src_oor = oor_reg[gk-1];
                end
                assign src_valid[gk] = dv_reg[gk-1];
            end

            // largest multiple of the digit weight that fits gives the digit
            always_comb
            begin
                diff_t  diff;
                digit_t d;
                code_t  r;
                diff = '0;
                d    = '0;
                r    = src_rem;
                for (int j = 1; j <= MAX_DIGIT; j++)
                begin
                    diff = {1'b0, src_rem} - digit_step(gk, j);
                    if (!diff[CODE_W])
                    begin
                        d = DIGIT_W'(j);
                        r = diff[CODE_W-1:0];
                    end
                end
                rem_next[gk] = r;
                for (int i = 0; i < NUM_DIGITS; i++)
                begin
                    dig_next[gk][i] = (i == gk) ? d : src_dig[i];
                end
                if (gk == 0)
                begin
                    diff = {1'b0, src_rem} - digit_step(gk, DIGIT_BASE);
                    oor_next[gk] = ~diff[CODE_W];
                end
                else
                begin
                    oor_next[gk] = src_oor;
                end
            end
        end
    endgenerate

    // apply every relabeling and compare against the original digit string
    always_comb
    begin
        digit_t nd [NUM_DIGITS];
        digit_t x;
        key_t   orig;
        key_t   key;
        int     dst;
        orig = '0;
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            orig[KEY_W-1-DIGIT_W*i -: DIGIT_W] = dig_reg[NUM_DIGITS-1][i];
        end
        for (int p = 0; p < NUM_PERMS; p++)
        begin
            for (int i = 0; i < NUM_DIGITS; i++)
            begin
                nd[i] = '0;
            end
            for (int s = 0; s < NUM_STATES; s++)
            begin
                for (int t = 0; t < 2; t++)
                begin
                    x   = dig_reg[NUM_DIGITS-1][NUM_DIGITS-1-2*s-t];
                    dst = NUM_DIGITS - 1 - 2 * int'(PERM_MAP[p][s]) - t;
                    nd[dst] = {map_state(p, x[DIGIT_W-1:STRIDE_W]), x[STRIDE_W-1:0]};
                end
            end
            key = '0;
            for (int i = 0; i < NUM_DIGITS; i++)
            begin
                key[KEY_W-1-DIGIT_W*i -: DIGIT_W] = nd[i];
            end
            eq_next[p] = (key == orig);
            lt_next[p] = (key < orig);
        end
    end

    always_comb
    begin
        if (coor_reg)
        begin
            mult_next  = '0;
            canon_next = 1'b0;
        end
        else
        begin
            mult_next  = orbit_size(MULT_W'($countones(eq_reg)));
            canon_next = ~(|lt_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_reg <= '0;
            cv_reg <= 1'b0;
            ov_reg <= 1'b0;
        end
        else
        begin
            for (int k = 0; k < NUM_DIGITS; k++)
            begin
                if (stage_rdy[k])
                begin
                    dv_reg[k] <= src_valid[k];
                end
            end
            if (cmp_rdy)
            begin
                cv_reg <= dv_reg[NUM_DIGITS-1];
            end
            if (out_rdy)
            begin
                ov_reg <= cv_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < NUM_DIGITS; k++)
        begin
            if (stage_rdy[k] && src_valid[k])
            begin
                rem_reg[k] <= rem_next[k];
                oor_reg[k] <= oor_next[k];
                for (int i = 0; i < NUM_DIGITS; i++)
                begin
                    dig_reg[k][i] <= dig_next[k][i];
                end
            end
        end
        if (cmp_rdy && dv_reg[NUM_DIGITS-1])
        begin
            eq_reg   <= eq_next;
            lt_reg   <= lt_next;
            coor_reg <= oor_reg[NUM_DIGITS-1];
        end
        if (out_rdy && cv_reg)
        begin
            mult_reg  <= mult_next;
            canon_reg <= canon_next;
            ooro_reg  <= coor_reg;
        end
    end

    assign result.valid        = ov_reg;
    assign result.multiplicity = mult_reg;
    assign result.is_canonical = canon_reg;
    assign result.out_of_range = ooro_reg;

endmodule

`default_nettype wire

// ===== bench/tb_turing_code_symmetry_canonicalizer_top.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the symmetry canonicaliser: random bursty requests, stalling results,
// own orbit predictor. Depends on tcsc_pkg and the channel interfaces in tcsc_if.sv.

module tb_turing_code_symmetry_canonicalizer_top;
    import tcsc_pkg::*;

    localparam bit [63:0] CODE_END  = 64'd10240000000000;  // 20^10
    localparam bit [63:0] CODE_SPAN = 64'd17592186044416;  // 2^44
    localparam int RADIX       = 20;
    localparam int RELABELINGS = 24;
    localparam int RANDOM_REQS = 700;
    localparam int HOLD_AT     = 300;  // results seen before the long receiver hold-off
    localparam int HOLD_CYCLES = 150;
    localparam int DRAIN_AT    = 500;  // requests accepted before the sender waits for drain
    localparam int TAIL_CYCLES = 16;

    typedef bit [9:0][4:0] digits_t;  // [0] is the most significant digit

    typedef struct packed {
        mult_t multiplicity;
        logic  is_canonical;
        logic  out_of_range;
    } orbit_t;

    typedef struct packed {
        bit [63:0] code;
        orbit_t    orbit;
    } outcome_t;

    logic clk;
    logic rst_n;

    tcsc_item_if   item_ch ();
    tcsc_result_if result_ch ();

    turing_code_symmetry_canonicalizer_top dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch)
    );

    bit [63:0] code_backlog [$];
    outcome_t  pending_orbits [$];
    int        error_count = 0;
    int        items_in = 0;
    int        results_out = 0;
    int        total_items = 0;
    logic      request_taken = 1'b0;

    int        burst_left = 1;
    int        gap_left = 0;
    int        hold_left = 0;
    bit        held = 1'b0;
    int        stall_mode = 0;
    int        mode_left = 0;

    outcome_t  want;
    bit [63:0] least_seen;

    task automatic queue_code(input bit [63:0] c);
        code_backlog = {code_backlog, c};
    endtask

    function automatic bit [4:0] tr(input int ns, input int wr, input int mv);
        return 5'(4 * ns + 2 * wr + mv);
    endfunction

    function automatic digits_t with_state(input digits_t d, input int s,
                                           input bit [4:0] on0, input bit [4:0] on1);
        d[9 - 2 * s] = on0;
        d[8 - 2 * s] = on1;
        return d;
    endfunction

    function automatic digits_t split_code(input bit [63:0] code);
        digits_t d;
        for (int i = 9; i >= 0; i--)
        begin
            d[i] = 5'(code % RADIX);
            code = code / RADIX;
        end
        return d;
    endfunction

    function automatic bit [63:0] join_digits(input digits_t d);
        bit [63:0] v;
        v = 64'd0;
        for (int i = 0; i < 10; i++)
        begin
            v = v * RADIX + 64'(d[i]);
        end
        return v;
    endfunction

    // Orbit size and canonical flag over every relabelling of states 1..4.
    function automatic orbit_t classify_code(input bit [63:0] code, output bit [63:0] least);
        digits_t   dig;
        digits_t   nd;
        bit [2:0]  lab [5];
        bit [4:0]  used;
        bit [2:0]  tgt;
        bit [2:0]  ns;
        bit [63:0] v;
        bit        ok;
        int        fixers;
        orbit_t    r;
        r = '0;
        least = code;
        fixers = 0;
        if (code >= CODE_END)
        begin
            r.out_of_range = 1'b1;
            return r;
        end
        dig = split_code(code);
        nd = '0;
        for (int sel = 0; sel < 256; sel++)
        begin
            ok = 1'b1;
            used = '0;
            lab[0] = 3'd0;
            for (int k = 0; k < 4; k++)
            begin
                tgt = 3'((sel >> (2 * k)) & 3) + 3'd1;
                if (used[tgt])
                    ok = 1'b0;
                used[tgt] = 1'b1;
                lab[k + 1] = tgt;
            end
            if (ok)
            begin
                for (int s = 0; s < 5; s++)
                begin
                    for (int t = 0; t < 2; t++)
                    begin
                        ns = 3'(dig[9 - 2 * s - t] / 4);
                        nd[9 - 2 * lab[s] - t] = 5'(4 * lab[ns] + dig[9 - 2 * s - t] % 4);
                    end
                end
                v = join_digits(nd);
                if (v == code)
                    fixers++;
                if (v < least)
                    least = v;
            end
        end
        r.multiplicity = mult_t'(RELABELINGS / fixers);
        r.is_canonical = (least == code);
        return r;
    endfunction

    task automatic flag_mismatch(input string what);
        error_count++;
        $display("MISMATCH at %0t ns: %s", $time, what);
    endtask

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    // stimulus
    initial
    begin
        digits_t   m;
        bit [63:0] code;
        bit [63:0] least;
        int        pick;
        int        kind;
        int        target;
        int        tpl_sel [2][2];
        int        tpl_wm [2][2];
        orbit_t    dummy;

        rst_n = 1'b0;
        item_ch.valid = 1'b0;
        item_ch.machine_code = '0;
        result_ch.ready = 1'b0;

        // field extremes and the out-of-range boundary
        queue_code(64'd0);
        queue_code(CODE_END - 1);
        queue_code(CODE_END);
        queue_code(CODE_SPAN - 1);
        queue_code(64'h0000_0800_0000_0000);

        // all of states 1..4 alike, halting into state 0
        m = '0;
        for (int s = 1; s <= 4; s++)
            m = with_state(m, s, tr(0, 1, 0), tr(0, 0, 1));
        queue_code(join_digits(m));
        // start state leads to state 3, breaking part of that symmetry
        m = with_state(m, 0, tr(3, 1, 1), tr(3, 0, 0));
        queue_code(join_digits(m));

        // states 1..4 in a ring, each pointing at the next
        m = '0;
        for (int s = 1; s <= 4; s++)
            m = with_state(m, s, tr(s % 4 + 1, 1, 1), tr(0, 0, 1));
        queue_code(join_digits(m));

        // two pairs pointing at each other
        m = '0;
        for (int s = 1; s <= 4; s++)
            m = with_state(m, s, tr(((s - 1) ^ 1) + 1, 1, 0), tr(s, 0, 0));
        queue_code(join_digits(m));

        // states 1..3 in a ring, plus a lone state
        m = '0;
        for (int s = 1; s <= 3; s++)
            m = with_state(m, s, tr(s % 3 + 1, 1, 0), tr(0, 0, 1));
        m = with_state(m, 4, tr(0, 1, 1), tr(0, 0, 0));
        queue_code(join_digits(m));

        // three alike, one odd
        m = '0;
        for (int s = 1; s <= 3; s++)
            m = with_state(m, s, tr(0, 1, 0), tr(0, 0, 1));
        m = with_state(m, 4, tr(0, 0, 0), tr(0, 1, 1));
        queue_code(join_digits(m));
        // two alike, two distinct
        m = with_state(m, 3, tr(0, 1, 1), tr(0, 1, 1));
        queue_code(join_digits(m));
        // two groups of two
        m = with_state(m, 4, tr(0, 1, 1), tr(0, 1, 1));
        queue_code(join_digits(m));

        // no symmetry at all, then its canonical form
        m = '0;
        for (int s = 1; s <= 4; s++)
            m = with_state(m, s, tr(s, (s >> 1) & 1, s & 1), tr(5 - s, 1, 0));
        code = join_digits(m);
        queue_code(code);
        dummy = classify_code(code, least);
        queue_code(least);

        code = 64'd12345678901;
        queue_code(code);
        dummy = classify_code(code, least);
        queue_code(least);

        for (int n = 0; n < RANDOM_REQS; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 30)
            begin
                for (int i = 0; i < 10; i++)
                    m[i] = 5'($urandom_range(0, 19));
                code = join_digits(m);
                if ($urandom_range(0, 3) == 0)
                    dummy = classify_code(code, code);
            end
            else if (pick < 75)
            begin
                // states 1..4 built from two templates so that symmetric codes are common
                for (int k = 0; k < 2; k++)
                begin
                    for (int t = 0; t < 2; t++)
                    begin
                        tpl_sel[k][t] = $urandom_range(0, 2);
                        tpl_wm[k][t] = $urandom_range(0, 3);
                    end
                end
                m[8] = 5'($urandom_range(0, 19));
                m[9] = 5'($urandom_range(0, 19));
                for (int s = 1; s <= 4; s++)
                begin
                    kind = $urandom_range(0, 1);
                    for (int t = 0; t < 2; t++)
                    begin
                        case (tpl_sel[kind][t])
                            0:       target = 0;
                            1:       target = s;
                            default: target = s % 4 + 1;
                        endcase
                        m[9 - 2 * s - t] = 5'(4 * target + tpl_wm[kind][t]);
                    end
                end
                code = join_digits(m);
                if ($urandom_range(0, 1) == 0)
                    dummy = classify_code(code, code);
            end
            else if (pick < 88)
                code = CODE_END + ({$urandom, $urandom} % (CODE_SPAN - CODE_END));
            else
                code = {20'd0, 12'($urandom_range(0, 4095)), $urandom} & (CODE_SPAN - 1);
            queue_code(code);
        end
        total_items = code_backlog.size();

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (items_in < total_items)
            @(posedge clk);
        while (pending_orbits.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("simulation failed");
        $finish;
    end

    // request driver: bursts with random gaps, one pause to let the pipe drain
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!item_ch.valid || request_taken)
            begin
                if (items_in == DRAIN_AT && pending_orbits.size() != 0)
                    item_ch.valid <= 1'b0;
                else if (gap_left > 0)
                begin
                    gap_left--;
                    item_ch.valid <= 1'b0;
                end
                else if (code_backlog.size() != 0)
                begin
                    item_ch.machine_code <= code_t'(code_backlog.pop_front());
                    item_ch.valid <= 1'b1;
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        burst_left = $urandom_range(1, 40);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
                else
                    item_ch.valid <= 1'b0;
            end
        end
    end

    // result receiver: stall density changes in phases, plus one long hold-off
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_left > 0)
            begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end
            else if (results_out == HOLD_AT && !held)
            begin
                held = 1'b1;
                hold_left = HOLD_CYCLES;
                result_ch.ready <= 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    stall_mode = $urandom_range(0, 3);
                    mode_left = $urandom_range(20, 80);
                end
                else
                    mode_left--;
                result_ch.ready <= ($urandom_range(0, 3) >= stall_mode);
            end
        end
    end

    // monitor: predict on each accepted request, check each accepted result
    always @(posedge clk)
    begin
        if (!rst_n)
            request_taken <= 1'b0;
        else
        begin
            request_taken <= item_ch.valid && item_ch.ready;
            if (item_ch.valid && item_ch.ready)
            begin
                want.code = 64'(item_ch.machine_code);
                want.orbit = classify_code(want.code, least_seen);
                pending_orbits = {pending_orbits, want};
                items_in++;
            end
            if (result_ch.valid && result_ch.ready)
            begin
                results_out++;
                if (pending_orbits.size() == 0)
                    flag_mismatch("result with no request outstanding");
                else
                begin
                    want = pending_orbits.pop_front();
                    if (result_ch.multiplicity !== want.orbit.multiplicity)
                        flag_mismatch($sformatf("code %0d multiplicity %0d, expected %0d",
                            want.code, result_ch.multiplicity, want.orbit.multiplicity));
                    if (result_ch.is_canonical !== want.orbit.is_canonical)
                        flag_mismatch($sformatf("code %0d is_canonical %b, expected %b",
                            want.code, result_ch.is_canonical, want.orbit.is_canonical));
                    if (result_ch.out_of_range !== want.orbit.out_of_range)
                        flag_mismatch($sformatf("code %0d out_of_range %b, expected %b",
                            want.code, result_ch.out_of_range, want.orbit.out_of_range));
                end
            end
        end
    end

endmodule
